[sv/smmf_pkg.sv]
package smmf_pkg;

   localparam int DATA_W    = 8;
   localparam int KS_W      = 5;
   localparam int CSR_IDX_W = 2;
   localparam int GROUP_W   = 8;   // entries per first-level reduction group

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIN_LEN     = 2'd0,
      CSR_USE_MIN     = 2'd1,
      CSR_PAD_VALUE   = 2'd2
   } csr_index_type;

   // control travelling alongside a window snapshot or a partial result
   typedef struct packed {
      logic valid;
      logic last;
   } stage_ctl_type;

endpackage

[sv/smmf_window.sv]
module smmf_window import smmf_pkg::*; #(
   parameter int MAX_KERNEL = 31,
   parameter int RW         = 5
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [DATA_W-1:0]                  req_tdata,
   input  logic                               req_tlast,
   input  logic [RW-1:0]                      radius,
   input  logic                               down_ready,
   output stage_ctl_type                      win_ctl,
   output logic [MAX_KERNEL-1:0][DATA_W-1:0]  win_data,
   output logic [MAX_KERNEL-1:0]              win_vld
);

   logic [MAX_KERNEL-1:0][DATA_W-1:0] data_ff, data_in;
   logic [MAX_KERNEL-1:0]             vld_ff, vld_in;
   stage_ctl_type                     ctl_ff, ctl_in;
   logic [RW-1:0]                     seen_ff, seen_in;
   logic [RW-1:0]                     flush_ff, flush_in;
   logic                              row_new_ff, row_new_in;

   logic          adv, accept, flush_step, emit_now;
   logic [RW-1:0] n_old, n_new;

   assign adv        = !ctl_ff.valid || down_ready;
   assign req_tready = adv && (flush_ff == '0);
   assign accept     = req_tvalid && req_tready;
   assign flush_step = adv && (flush_ff != '0);

   assign n_old    = (seen_ff > radius) ? radius : seen_ff;
   assign emit_now = (n_old == radius);
   assign n_new    = emit_now ? n_old : n_old + RW'(1);

   always_comb begin
      data_in    = data_ff;
      vld_in     = vld_ff;
      ctl_in     = ctl_ff;
      seen_in    = seen_ff;
      flush_in   = flush_ff;
      row_new_in = row_new_ff;
      if (adv) begin
         ctl_in.valid = 1'b0;
         ctl_in.last  = 1'b0;
      end
      if (accept) begin
         // a new row forgets the previous row's samples
         for (int k = 1; k < MAX_KERNEL; k++) begin
            data_in[k] = data_ff[k-1];
            vld_in[k]  = vld_ff[k-1] && !row_new_ff;
         end
         data_in[0]   = req_tdata;
         vld_in[0]    = 1'b1;
         ctl_in.valid = emit_now;
         ctl_in.last  = req_tlast && (n_new == '0);
         seen_in      = req_tlast ? '0 : n_new;
         flush_in     = req_tlast ? n_new : '0;
         row_new_in   = req_tlast;
      end else if (flush_step) begin
         // trailing border: shift in pad positions
         for (int k = 1; k < MAX_KERNEL; k++) begin
            data_in[k] = data_ff[k-1];
            vld_in[k]  = vld_ff[k-1];
         end
         data_in[0]   = '0;
         vld_in[0]    = 1'b0;
         ctl_in.valid = 1'b1;
         ctl_in.last  = (flush_ff == RW'(1));
         flush_in     = flush_ff - RW'(1);
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         vld_ff     <= '0;
         ctl_ff     <= '0;
         seen_ff    <= '0;
         flush_ff   <= '0;
         row_new_ff <= 1'b1;
      end else begin
         vld_ff     <= vld_in;
         ctl_ff     <= ctl_in;
         seen_ff    <= seen_in;
         flush_ff   <= flush_in;
         row_new_ff <= row_new_in;
      end
   end

   assign win_ctl  = ctl_ff;
   assign win_data = data_ff;
   assign win_vld  = vld_ff;

endmodule

[sv/smmf_reduce.sv]
module smmf_reduce import smmf_pkg::*; #(
   parameter int MAX_KERNEL = 31,
   parameter int RW         = 5,
   parameter int NG         = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  stage_ctl_type                      win_ctl,
   input  logic [MAX_KERNEL-1:0][DATA_W-1:0]  win_data,
   input  logic [MAX_KERNEL-1:0]              win_vld,
   input  logic [RW-1:0]                      radius,
   input  logic                               use_min,
   input  logic [DATA_W-1:0]                  pad_value,
   input  logic                               down_ready,
   output logic                               up_ready,
   output stage_ctl_type                      grp_ctl,
   output logic [NG-1:0][DATA_W-1:0]          grp_min
);

   // max mode runs as a minimum over complemented values
   logic [MAX_KERNEL-1:0][DATA_W-1:0] term;
   logic [NG-1:0][DATA_W-1:0]         grp_ff, grp_in;
   stage_ctl_type                     ctl_ff;

   always_comb begin
      for (int k = 0; k < MAX_KERNEL; k++) begin
         if (k > 2 * int'(radius))
            term[k] = '1;
         else if (!win_vld[k])
            term[k] = pad_value;
         else
            term[k] = use_min ? win_data[k] : ~win_data[k];
      end
      for (int g = 0; g < NG; g++) begin
         grp_in[g] = '1;
         for (int j = 0; j < GROUP_W; j++) begin
            if (g * GROUP_W + j < MAX_KERNEL) begin
               if (term[g * GROUP_W + j] < grp_in[g])
                  grp_in[g] = term[g * GROUP_W + j];
            end
         end
      end
   end

   assign up_ready = !ctl_ff.valid || down_ready;

   always_ff @(posedge clock) begin
      if (up_ready)
         grp_ff <= grp_in;
      if (reset) begin
         ctl_ff <= '0;
      end else if (up_ready) begin
         ctl_ff <= win_ctl;
      end
   end

   assign grp_ctl = ctl_ff;
   assign grp_min = grp_ff;

endmodule

[sv/smmf_out.sv]
module smmf_out import smmf_pkg::*; #(
   parameter int NG = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  stage_ctl_type              grp_ctl,
   input  logic [NG-1:0][DATA_W-1:0]  grp_min,
   input  logic                       use_min,
   output logic                       up_ready,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [DATA_W-1:0]          rsp_tdata,
   output logic                       rsp_tlast
);

   logic [DATA_W-1:0] min_all, data_ff;
   logic              valid_ff, last_ff;

   always_comb begin
      min_all = '1;
      for (int g = 0; g < NG; g++) begin
         if (grp_min[g] < min_all)
            min_all = grp_min[g];
      end
   end

   assign up_ready = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (up_ready) begin
         data_ff <= use_min ? min_all : ~min_all;
         last_ff <= grp_ctl.last;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= grp_ctl.valid;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

[sv/sliding_minmax_filter_row.sv]
// Sliding min/max filter over one row of 8-bit samples.
// A result passes through the window, group-reduction and result registers on its way to rsp.
// Throughput: one request per cycle while the result channel is not stalled; after the last
//   request of a row req_tready stays low while the pending outputs (radius, or fewer on a
//   row shorter than the radius) are flushed, longer while the result channel is stalled.
// Reset (synchronous, active high): empty window, no pending results, registers at
//   window length 3, use_min 1, pad_value 255.
module sliding_minmax_filter_row import smmf_pkg::*; #(
   parameter int MAX_KERNEL = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,    // [7:0] sample
   input  logic                  req_tlast,    // last_of_row
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,    // [7:0] filtered
   output logic                  rsp_tlast,    // last
   // register writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [7:0]            csr_wdata
);

   localparam int RMAX = (MAX_KERNEL - 1) / 2;
   localparam int RW   = $clog2(RMAX + 2);
   localparam int NG   = (MAX_KERNEL + GROUP_W - 1) / GROUP_W;

   // --- configuration registers ---
   logic [KS_W-1:0]   ks_ff;
   logic              use_min_ff;
   logic [DATA_W-1:0] pad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ks_ff      <= KS_W'(3);
         use_min_ff <= 1'b1;
         pad_ff     <= '1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIN_LEN:     ks_ff      <= csr_wdata[KS_W-1:0];
            CSR_USE_MIN:     use_min_ff <= csr_wdata[0];
            CSR_PAD_VALUE:   pad_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // radius: even kernels round down, zero acts as one, capped by the window depth
   logic [KS_W-1:0] r_raw;
   logic [RW-1:0]   radius;

   assign r_raw  = (ks_ff == '0) ? '0 : ((ks_ff - KS_W'(1)) >> 1);
   assign radius = (int'(r_raw) > RMAX) ? RW'(RMAX) : RW'(r_raw);

   // max mode pads with the complement of pad_value; the reduction works on
   // complemented data in max mode, so pad_value itself goes in either way
   // --- window shift register and flush sequencer ---
   stage_ctl_type                     win_ctl, grp_ctl;
   logic [MAX_KERNEL-1:0][DATA_W-1:0] win_data;
   logic [MAX_KERNEL-1:0]             win_vld;
   logic [NG-1:0][DATA_W-1:0]         grp_min;
   logic                              red_ready, out_ready;

   smmf_window #(.MAX_KERNEL(MAX_KERNEL), .RW(RW)) u_window (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .radius     (radius),
      .down_ready (red_ready),
      .win_ctl    (win_ctl),
      .win_data   (win_data),
      .win_vld    (win_vld)
   );

   // --- first-level reduction: groups of eight, registered ---
   smmf_reduce #(.MAX_KERNEL(MAX_KERNEL), .RW(RW), .NG(NG)) u_reduce (
      .clock      (clock),
      .reset      (reset),
      .win_ctl    (win_ctl),
      .win_data   (win_data),
      .win_vld    (win_vld),
      .radius     (radius),
      .use_min    (use_min_ff),
      .pad_value  (pad_ff),
      .down_ready (out_ready),
      .up_ready   (red_ready),
      .grp_ctl    (grp_ctl),
      .grp_min    (grp_min)
   );

   // --- final reduction and result register ---
   smmf_out #(.NG(NG)) u_out (
      .clock      (clock),
      .reset      (reset),
      .grp_ctl    (grp_ctl),
      .grp_min    (grp_min),
      .use_min    (use_min_ff),
      .up_ready   (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // --- checks ---
   // a row end with a nonzero radius always starts a flush, blocking requests
   a_flush_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast && radius != '0) |=> !req_tready)
      else $error("request taken during row flush");

   // a window snapshot awaiting the reducer must not move
   a_window_holds: assert property (@(posedge clock) disable iff (reset)
      (win_ctl.valid && !red_ready) |=> ($stable(win_vld) && $stable(win_data)))
      else $error("window changed under a stalled snapshot");

   // the reducer only stalls when the result register is full and not taken
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !red_ready |-> (rsp_tvalid && !rsp_tready))
      else $error("reducer stalled without output backpressure");

endmodule

[bench/tb_sliding_minmax_filter_row.sv]
module tb_sliding_minmax_filter_row import smmf_pkg::*; ();

   // Window depth of the block under test.
   // Hold-off before a register write: covers the window, reduction and result registers plus margin.
   localparam int WIN_DEPTH      = 31;
   localparam int HOLD_OFF       = 8;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_ITEMS   = 330;
   localparam int STEADY_ITEMS   = 80;

   // index with no register behind it; a write there must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } filt_result_type;

   // shape of the sample values within one random row
   typedef enum int {
      ROW_NOISE,
      ROW_NARROW,
      ROW_EXTREMES
   } row_kind_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = '0;
   logic                 req_tlast  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [7:0]           csr_wdata  = '0;

   // random idling on both channels; cleared for the steady-stream stretch
   logic stalls_on = 1'b1;

   int unsigned fail_count  = 0;
   int unsigned idle_cycles = 0;

   // expected filter outputs, oldest first
   filt_result_type expected_results[$];

   // shadow of the filter: window contents (newest at 0), border flags, fill count
   logic [7:0]           win_value[WIN_DEPTH];
   logic [WIN_DEPTH-1:0] win_valid = '0;
   int unsigned          seen_count = 0;

   // shadow of the register file, reset values
   logic [4:0] cfg_kernel  = 5'd3;
   logic       cfg_use_min = 1'b1;
   logic [7:0] cfg_pad     = 8'hFF;

   sliding_minmax_filter_row #(
      .MAX_KERNEL(WIN_DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] sample
      .req_tlast  (req_tlast),    // last_of_row
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [7:0] filtered
      .rsp_tlast  (rsp_tlast),    // last
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Filter prediction
   // ---------------------------------------------------------------------

   // Half window; kernel 0 acts as 1, even sizes round down to odd.
   // Saturation at the window depth is kept although 5 bits cannot reach it.
   function automatic int unsigned kernel_radius();
      int unsigned r;
      r = (cfg_kernel == 5'd0) ? 0 : (int'(cfg_kernel) - 1) >> 1;
      return (r > (WIN_DEPTH - 1) / 2) ? (WIN_DEPTH - 1) / 2 : r;
   endfunction

   // max mode borders with the complement so the pad never wins by default
   function automatic logic [7:0] border_value();
      return cfg_use_min ? cfg_pad : ~cfg_pad;
   endfunction

   function automatic void shift_window(input logic [7:0] v, input logic is_sample);
      for (int k = WIN_DEPTH - 1; k > 0; k--)
         win_value[k] = win_value[k-1];
      win_value[0] = v;
      win_valid    = {win_valid[WIN_DEPTH-2:0], is_sample};
   endfunction

   function automatic logic [7:0] window_extreme(input int unsigned r);
      logic [7:0] acc;
      logic [7:0] v;
      acc = '0;
      for (int k = 0; k <= 2 * r && k < WIN_DEPTH; k++) begin
         v = win_valid[k] ? win_value[k] : border_value();
         if (k == 0)
            acc = v;
         else if (cfg_use_min)
            acc = (v < acc) ? v : acc;
         else
            acc = (v > acc) ? v : acc;
      end
      return acc;
   endfunction

   // Called once per accepted request; queues every output it releases.
   // The row end flushes one output per pending position, the final one flagged.
   function automatic void predict_filtered(input logic [7:0] sample, input logic row_end);
      int unsigned     r;
      int unsigned     n;
      filt_result_type res;
      r = kernel_radius();
      n = (seen_count > r) ? r : seen_count;
      shift_window(sample, 1'b1);
      if (n >= r) begin
         // centre output; it is the row's last only when nothing is left to flush
         res.value = window_extreme(r);
         res.last  = row_end && (r == 0);
         expected_results.push_back(res);
      end
      if (n < r)
         n++;
      seen_count = n;
      if (row_end) begin
         for (int unsigned t = 0; t < n; t++) begin
            shift_window(8'h00, 1'b0);
            res.value = window_extreme(r);
            res.last  = (t == n - 1);
            expected_results.push_back(res);
         end
         win_valid  = '0;
         seen_count = 0;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Result checking: every accepted result against the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      filt_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result with none expected, actual filtered %02h last %b",
                     $time, rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata !== want.value) begin
               $display("%0t: filtered mismatch, expected %02h, actual %02h",
                        $time, want.value, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last mismatch, expected %b, actual %b",
                        $time, want.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // result-side back-pressure, about 30 percent of the time while stalls are on
   always @(negedge clock) begin
      rsp_tready <= !stalls_on || ($urandom_range(99) >= 30);
   end

   // watchdog: too long without any request or result accepted
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Drivers; every task starts and ends at a falling edge
   // ---------------------------------------------------------------------

   // One request. tvalid stays high on return so back-to-back requests
   // never see it dropped and raised within one step.
   task automatic send_request(input logic [7:0] sample, input logic row_end);
      while (stalls_on && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      req_tlast  <= row_end;
      do
         @(posedge clock);
      while (!req_tready);
      predict_filtered(sample, row_end);
      @(negedge clock);
   endtask

   // Drain: all expected results in, then a pause for work with no output yet.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0)
         @(negedge clock);
      repeat (HOLD_OFF) @(negedge clock);
   endtask

   // write strobe for one cycle, then the strobe is dropped before the next driver starts
   task automatic csr_write(input logic [CSR_IDX_W-1:0] index, input logic [7:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      if (index == CSR_WIN_LEN)
         cfg_kernel = data[4:0];
      else if (index == CSR_USE_MIN)
         cfg_use_min = data[0];
      else if (index == CSR_PAD_VALUE)
         cfg_pad = data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // random register; upper write-data bits are noise the block must ignore
   task automatic random_csr_write();
      logic [7:0] data;
      int unsigned pick;
      data = 8'($urandom);
      pick = $urandom_range(19);
      if (pick < 7) begin
         if ($urandom_range(7) == 0)
            data[4:0] = 5'd31;
         csr_write(CSR_WIN_LEN, data);
      end else if (pick < 12) begin
         csr_write(CSR_USE_MIN, data);
      end else if (pick < 19) begin
         case ($urandom_range(5))
            0: data = 8'h00;
            1: data = 8'hFF;
            default: ;
         endcase
         csr_write(CSR_PAD_VALUE, data);
      end else begin
         csr_write(CSR_SPARE, data);
      end
   endtask

   function automatic logic [7:0] pick_sample(input row_kind_type kind,
                                              input logic [7:0] base);
      case (kind)
         ROW_NARROW:   return base + 8'($urandom_range(15));
         ROW_EXTREMES: return ($urandom_range(3) == 0) ? 8'($urandom) :
                              ($urandom_range(1) ? 8'hFF : 8'h00);
         default:      return 8'($urandom);
      endcase
   endfunction

   // Whole rows of random length and content; reconfigure between many rows
   // and now and then in the middle of one.
   task automatic run_random_rows(input int unsigned target);
      int unsigned  sent;
      int unsigned  row_len;
      int unsigned  cut_at;
      row_kind_type kind;
      logic [7:0]   base;
      sent = 0;
      while (sent < target) begin
         if ($urandom_range(1) == 0) begin
            wait_idle();
            repeat ($urandom_range(1, 3)) random_csr_write();
         end
         row_len = ($urandom_range(3) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
         kind    = row_kind_type'($urandom_range(2));
         base    = 8'($urandom);
         cut_at  = (row_len > 2 && $urandom_range(9) == 0) ? $urandom_range(1, row_len - 1)
                                                           : 0;
         for (int unsigned i = 0; i < row_len; i++) begin
            if (cut_at != 0 && i == cut_at) begin
               wait_idle();
               random_csr_write();
            end
            send_request(pick_sample(kind, base), i == row_len - 1);
         end
         sent += row_len;
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // reset config: kernel 3, min, pad 255; extreme samples
   task automatic test_reset_defaults();
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'h07, 1'b0);
      send_request(8'hC8, 1'b1);
   endtask

   // radius 0: each request gives its own output; kernel 0 behaves as 1
   task automatic test_kernel_one();
      wait_idle();
      csr_write(CSR_WIN_LEN, 8'hE1);
      send_request(8'hFF, 1'b0);
      send_request(8'h00, 1'b0);
      send_request(8'h80, 1'b1);
      wait_idle();
      csr_write(CSR_WIN_LEN, 8'h00);
      send_request(8'h09, 1'b1);
   endtask

   // even size rounds down; widest kernel with rows shorter than the radius
   task automatic test_wide_kernel();
      wait_idle();
      csr_write(CSR_WIN_LEN, 8'h04);
      send_request(8'h03, 1'b0);
      send_request(8'hFA, 1'b0);
      send_request(8'h01, 1'b1);
      wait_idle();
      csr_write(CSR_WIN_LEN, 8'h1F);
      send_request(8'h11, 1'b0);
      send_request(8'hF0, 1'b0);
      send_request(8'h05, 1'b1);
      send_request(8'h42, 1'b1);
   endtask

   // max filter, border is the complement of the pad
   task automatic test_max_mode();
      wait_idle();
      csr_write(CSR_USE_MIN, 8'hFE);
      csr_write(CSR_PAD_VALUE, 8'h5A);
      csr_write(CSR_WIN_LEN, 8'h05);
      send_request(8'h5A, 1'b0);
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'h0C, 1'b1);
   endtask

   // registers rewritten part-way through a row take effect at once
   task automatic test_mid_row_write();
      wait_idle();
      csr_write(CSR_USE_MIN, 8'h01);
      csr_write(CSR_WIN_LEN, 8'h03);
      send_request(8'h28, 1'b0);
      send_request(8'h1E, 1'b0);
      send_request(8'h14, 1'b0);
      wait_idle();
      csr_write(CSR_WIN_LEN, 8'h07);
      csr_write(CSR_PAD_VALUE, 8'h10);
      send_request(8'h32, 1'b0);
      send_request(8'h3C, 1'b1);
   endtask

   task automatic test_random_rows();
      stalls_on = 1'b1;
      run_random_rows(RANDOM_ITEMS);
   endtask

   // full rate on both channels
   task automatic test_steady_stream();
      wait_idle();
      stalls_on = 1'b0;
      run_random_rows(STEADY_ITEMS);
      wait_idle();
      stalls_on = 1'b1;
   endtask

   initial begin
      for (int k = 0; k < WIN_DEPTH; k++)
         win_value[k] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_kernel_one();
      test_wide_kernel();
      test_max_mode();
      test_mid_row_write();
      test_random_rows();
      test_steady_stream();

      // drain, then watch a while for stray results
      wait_idle();
      repeat (2 * HOLD_OFF) @(negedge clock);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
